FILE: hw/rtl/ibsm_pkg.sv
// Shared types and constants for the IMU bias, scale and misalignment compensator.
// Holds action codes, register indexes, queue sizing and the matrix coefficient selector.
// No dependencies.
package ibsm_pkg;

  localparam int COEF_BITS      = 16;
  localparam int REG_BITS       = 3 * COEF_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] ACT_COMP = 2'd0;
  localparam logic [1:0] ACT_ACC  = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GYRO_SCALE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GYRO_MIS    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_SCALE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_MIS   = 3'd3;

  // Three Q2.14 ones packed side by side.
  localparam logic [REG_BITS-1:0] SCALE_RESET = 48'h4000_4000_4000;

  // Tag that travels with each item from the front to the back.
  typedef struct packed {
    logic comp;
    logic sat;
  } ibsm_tag_t;

  // Entry (i, j) of the symmetric matrix: scale on the diagonal, the
  // misalignment terms xy, xz, yz elsewhere (their field is i + j - 1).
  function automatic logic signed [COEF_BITS-1:0] mat_coef(
      input logic [REG_BITS-1:0] scale, input logic [REG_BITS-1:0] mis,
      input int i, input int j);
    logic signed [COEF_BITS-1:0] c;
    if (i == j) begin
      c = scale[i*COEF_BITS +: COEF_BITS];
    end else begin
      c = mis[(i+j-1)*COEF_BITS +: COEF_BITS];
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/ibsm_in_if.sv
// Input channel of the compensator: one item with an action and six samples.
// Width follows SAMPLE_BITS; no other dependencies.
interface ibsm_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] gyro_x;
  logic signed [SAMPLE_BITS-1:0] gyro_y;
  logic signed [SAMPLE_BITS-1:0] gyro_z;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, action, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, action, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

FILE: hw/rtl/ibsm_out_if.sv
// Result channel of the compensator: six values and a saturation flag.
// Width follows SAMPLE_BITS; no other dependencies.
interface ibsm_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_gyro_x;
  logic signed [SAMPLE_BITS-1:0] out_gyro_y;
  logic signed [SAMPLE_BITS-1:0] out_gyro_z;
  logic signed [SAMPLE_BITS-1:0] out_accel_x;
  logic signed [SAMPLE_BITS-1:0] out_accel_y;
  logic signed [SAMPLE_BITS-1:0] out_accel_z;
  logic                          saturated;

  modport source (output valid, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
                  out_accel_y, out_accel_z, saturated, input ready);
  modport sink (input valid, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
                out_accel_y, out_accel_z, saturated, output ready);
endinterface

FILE: hw/rtl/ibsm_front.sv
// Front end: accepts items, keeps the bias stores and applies bias actions in order.
// Compensate items leave with their bias differences. Uses ibsm_pkg and ibsm_in_if.
module ibsm_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  ibsm_in_if.sink                           samples,
  output logic                              push_valid,
  input  logic                              push_ready,
  output ibsm_pkg::ibsm_tag_t               push_tag,
  output logic [5:0][SAMPLE_BITS:0]         push_vals
);
  import ibsm_pkg::*;

  localparam int DW = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] raw       [6];
  logic signed [SAMPLE_BITS-1:0] bias      [6];
  logic signed [SAMPLE_BITS-1:0] bias_next [6];
  logic signed [DW-1:0]          sum       [6];
  logic signed [SAMPLE_BITS-1:0] clipped   [6];
  logic [5:0]                    hit;
  logic                          accept;

  assign raw[0] = samples.gyro_x;
  assign raw[1] = samples.gyro_y;
  assign raw[2] = samples.gyro_z;
  assign raw[3] = samples.accel_x;
  assign raw[4] = samples.accel_y;
  assign raw[5] = samples.accel_z;

  assign samples.ready = push_ready;
  assign push_valid    = samples.valid;
  assign accept        = samples.valid && push_ready;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sum[k] = {raw[k][SAMPLE_BITS-1], raw[k]} + {bias[k][SAMPLE_BITS-1], bias[k]};
      // The sum left the sample range when its two top bits disagree.
      hit[k] = sum[k][DW-1] != sum[k][DW-2];
      if (hit[k]) begin
        clipped[k] = sum[k][DW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        clipped[k] = sum[k][SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    push_tag = '0;
    for (int k = 0; k < 6; k++) begin
      bias_next[k] = bias[k];
    end
    unique case (samples.action)
      ACT_COMP: begin
        push_tag.comp = 1'b1;
      end
      ACT_ACC: begin
        push_tag.sat = |hit;
        for (int k = 0; k < 6; k++) begin
          bias_next[k] = clipped[k];
        end
      end
      ACT_LOAD: begin
        for (int k = 0; k < 6; k++) begin
          bias_next[k] = raw[k];
        end
      end
      ACT_NONE: begin
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      if (push_tag.comp) begin
        push_vals[k] = {raw[k][SAMPLE_BITS-1], raw[k]} - {bias[k][SAMPLE_BITS-1], bias[k]};
      end else begin
        push_vals[k] = {bias_next[k][SAMPLE_BITS-1], bias_next[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        bias[k] <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < 6; k++) begin
        bias[k] <= bias_next[k];
      end
    end
  end

endmodule

FILE: hw/rtl/ibsm_queue.sv
// Short FIFO that separates the front end from the arithmetic back end.
// Depth comes from ibsm_pkg; payload width is a parameter.
module ibsm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import ibsm_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = count != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ibsm_back.sv
// Back end: coefficient registers, a multiply stage and a sum, round and clip stage
// that feeds the output register. Uses ibsm_pkg and ibsm_out_if.
module ibsm_back #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ibsm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ibsm_pkg::REG_BITS-1:0]        cfg_data,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  ibsm_pkg::ibsm_tag_t                  pop_tag,
  input  logic [5:0][SAMPLE_BITS:0]            pop_vals,
  ibsm_out_if.source                           results
);
  import ibsm_pkg::*;

  localparam int DW  = SAMPLE_BITS + 1;
  localparam int PW  = COEF_BITS + DW;
  localparam int SW  = (PW + 2 > COEF_FRAC_BITS + 2) ? PW + 2 : COEF_FRAC_BITS + 2;
  localparam logic signed [SW-1:0] RND =
      {{(SW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] HI = {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] LO = ~HI;

  logic [REG_BITS-1:0] scale [2];
  logic [REG_BITS-1:0] mis   [2];

  logic signed [PW-1:0]          prod_d [2][3][3];
  logic signed [PW-1:0]          prod   [2][3][3];
  logic signed [SAMPLE_BITS-1:0] byp    [6];
  ibsm_tag_t                     s1_tag;
  logic                          s1_valid;
  logic                          s1_adv;
  logic                          s2_adv;

  logic signed [SW-1:0]          acc    [6];
  logic signed [SW-1:0]          quo    [6];
  logic signed [SAMPLE_BITS-1:0] res_d  [6];
  logic [5:0]                    hit;
  logic signed [SAMPLE_BITS-1:0] res    [6];
  logic                          res_sat;
  logic                          res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0] <= SCALE_RESET;
      mis[0]   <= '0;
      scale[1] <= SCALE_RESET;
      mis[1]   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_SCALE:  scale[0] <= cfg_data;
        REG_GYRO_MIS:    mis[0]   <= cfg_data;
        REG_ACCEL_SCALE: scale[1] <= cfg_data;
        REG_ACCEL_MIS:   mis[1]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s2_adv    = !res_valid || results.ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign pop_ready = s1_adv;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_d[s][i][j] = mat_coef(scale[s], mis[s], i, j) * $signed(pop_vals[s*3+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && pop_valid) begin
      s1_tag <= pop_tag;
      prod   <= prod_d;
      for (int k = 0; k < 6; k++) begin
        byp[k] <= pop_vals[k][SAMPLE_BITS-1:0];
      end
    end
  end

  // Compensate items round to nearest, ties toward plus infinity, and clip to the sample range.
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < 3; i++) begin
        acc[s*3+i] = prod[s][i][0] + prod[s][i][1] + prod[s][i][2] + RND;
      end
    end
    for (int k = 0; k < 6; k++) begin
      quo[k] = acc[k] >>> COEF_FRAC_BITS;
      hit[k] = 1'b0;
      if (!s1_tag.comp) begin
        res_d[k] = byp[k];
      end else if (quo[k] > HI) begin
        res_d[k] = HI[SAMPLE_BITS-1:0];
        hit[k]   = 1'b1;
      end else if (quo[k] < LO) begin
        res_d[k] = LO[SAMPLE_BITS-1:0];
        hit[k]   = 1'b1;
      end else begin
        res_d[k] = quo[k][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      res_sat <= s1_tag.comp ? |hit : s1_tag.sat;
      for (int k = 0; k < 6; k++) begin
        res[k] <= res_d[k];
      end
    end
  end

  assign results.valid       = res_valid;
  assign results.out_gyro_x  = res[0];
  assign results.out_gyro_y  = res[1];
  assign results.out_gyro_z  = res[2];
  assign results.out_accel_x = res[3];
  assign results.out_accel_y = res[4];
  assign results.out_accel_z = res[5];
  assign results.saturated   = res_sat;

endmodule

FILE: hw/rtl/imu_bias_scale_misalign_comp.sv
// IMU bias, scale and misalignment compensator, top level.
// Connects the front end, the item queue and the arithmetic back end; uses ibsm_pkg.
//
// Items enter on the samples channel (valid/ready) with an action and six samples.
// A compensate item has the stored biases subtracted and each three-axis vector
// multiplied by its Q2.14 symmetric matrix; the rounded, clipped values leave on
// the results channel. Accumulate and load items update the biases in the front
// end and return the new biases. Every item gives exactly one result, in order.
// Throughput is one item per clock while the receiver takes results. An accepted
// item passes through the queue into the multiply register, then through the sum,
// round and clip into the output register, which drives the results channel.
// When the receiver stalls, the output register holds, the back end stops, and
// the four-entry queue fills; samples.ready drops only once the queue is full.
// Reset clears the biases to zero, loads unit scale and zero misalignment, and
// empties the queue and both pipeline registers. Configuration writes on cfg_we
// take effect at once and are meant for times when no item is in flight;
// indexes beyond the four registers are ignored.
module imu_bias_scale_misalign_comp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  ibsm_in_if.sink                             samples,
  ibsm_out_if.source                          results,
  input  logic                                cfg_we,
  input  logic [ibsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ibsm_pkg::REG_BITS-1:0]       cfg_data
);
  import ibsm_pkg::*;

  localparam int DW = SAMPLE_BITS + 1;
  localparam int QW = $bits(ibsm_tag_t) + 6 * DW;

  logic              push_valid;
  logic              push_ready;
  ibsm_tag_t         push_tag;
  logic [5:0][DW-1:0] push_vals;
  logic              pop_valid;
  logic              pop_ready;
  ibsm_tag_t         pop_tag;
  logic [5:0][DW-1:0] pop_vals;
  logic [QW-1:0]     pop_data;

  ibsm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_tag  (push_tag),
    .push_vals (push_vals)
  );

  ibsm_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_tag, push_vals}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  assign pop_tag  = pop_data[QW-1 -: $bits(ibsm_tag_t)];
  assign pop_vals = pop_data[6*DW-1:0];

  ibsm_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_tag  (pop_tag),
    .pop_vals (pop_vals),
    .results  (results)
  );

endmodule

FILE: hw/rtl/ibsm_chk.sv
// Port-level checks for the compensator, attached to the top level by bind.
// Tracks items in flight from the handshakes; uses ibsm_pkg.
module ibsm_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic                   res_sat,
  input logic [SAMPLE_BITS-1:0] res_gx
);
  import ibsm_pkg::*;

  // Queue entries plus the multiply register and the output register.
  localparam int MAX_FLIGHT = QUEUE_DEPTH + 2;
  localparam int FW         = $clog2(MAX_FLIGHT + 1);

  logic [FW-1:0] flight;
  logic          in_acc;
  logic          res_acc;

  assign in_acc  = in_valid && in_ready;
  assign res_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else if (in_acc && !res_acc) begin
      flight <= flight + 1'b1;
    end else if (res_acc && !in_acc) begin
      flight <= flight - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      res_valid && !res_ready |=> res_valid && $stable(res_gx) && $stable(res_sat))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
      res_valid |-> flight != '0)
    else $error("result without an item in flight");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
      flight == FW'(MAX_FLIGHT) |-> !in_ready)
    else $error("input ready with every stage and queue entry occupied");

endmodule

bind imu_bias_scale_misalign_comp ibsm_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (samples.valid),
  .in_ready (samples.ready),
  .res_valid(results.valid),
  .res_ready(results.ready),
  .res_sat  (results.saturated),
  .res_gx   (results.out_gyro_x)
);
